@@ hdl/rdra_pkg.sv @@
package rdra_pkg;

  // coordinate and register widths
  localparam int COORD_BITS = 10;
  localparam int SIZE_W = 11;
  localparam int K_W = 32;
  localparam int FOCAL_W = 12;
  localparam int SCALE_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;

  // offset from centre, signed
  localparam int D_W = ((COORD_BITS > SIZE_W - 1) ? COORD_BITS : SIZE_W - 1) + 1;
  // dx^2 + dy^2 + f^2
  localparam int S_W = ((2 * D_W - 1 > 24) ? 2 * D_W - 1 : 24) + 1;
  // radicand s * 2^16, rounded up to an even width
  localparam int N_W = S_W + 16 + ((S_W + 16) % 2);
  localparam int ROOT_W = N_W / 2;
  localparam int RMUL_W = ROOT_W + SCALE_W;
  // radius, Q8.16
  localparam int R_W = 24;
  localparam int R2_W = 32;
  localparam int TERM_W = K_W + R2_W + 1 - 24;
  localparam int SUM_W = TERM_W + 3;
  localparam int POLY_W = 32;
  localparam int NM_W = D_W + 14;
  localparam int PROD_W = NM_W + 24;

  // cordic and divider
  localparam int CORDIC_STEPS = 24;
  localparam int CX_W = 36;
  localparam int CZ_W = 27;
  localparam int Q_W = 25;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int POLY_STAGES = 6;

  localparam logic [Q_W-1:0] THETA_ONE = Q_W'(1) << 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_K1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_K2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_K3 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_LENGTH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_SCALE = 3'd6;

  // reset values
  localparam logic [SIZE_W-1:0] ROWS_RESET = 11'd400;
  localparam logic [SIZE_W-1:0] COLS_RESET = 11'd400;
  localparam logic signed [K_W-1:0] K1_RESET = -32'sd167772;
  localparam logic signed [K_W-1:0] K2_RESET = 32'sd0;
  localparam logic signed [K_W-1:0] K3_RESET = 32'sd0;
  localparam logic [FOCAL_W-1:0] FOCAL_RESET = 12'd200;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd10923;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_row;
    logic [COORD_BITS-1:0] dest_col;
  } remap_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] source_row;
    logic [COORD_BITS-1:0] source_col;
    logic                  outside;
  } remap_result_t;

  typedef struct packed {
    logic signed [K_W-1:0] k1;
    logic signed [K_W-1:0] k2;
    logic signed [K_W-1:0] k3;
  } coeff_t;

  // scaled offset of one axis: sign and magnitude of d*P/2^16
  typedef struct packed {
    logic            neg;
    logic [NM_W-1:0] nmag;
  } axis_t;

  // atan(2^-i) in Q.24
  function automatic logic [CZ_W-1:0] atan_entry(input int i);
    case (i)
      0: atan_entry = CZ_W'(13176795);
      1: atan_entry = CZ_W'(7778716);
      2: atan_entry = CZ_W'(4110060);
      3: atan_entry = CZ_W'(2086331);
      4: atan_entry = CZ_W'(1047214);
      5: atan_entry = CZ_W'(524117);
      6: atan_entry = CZ_W'(262123);
      7: atan_entry = CZ_W'(131069);
      default: begin
        if (i >= 8 && i < CORDIC_STEPS) begin
          atan_entry = CZ_W'(1) << (24 - i);
        end else begin
          atan_entry = '0;
        end
      end
    endcase
  endfunction

endpackage

@@ hdl/rdra_isqrt.sv @@
module rdra_isqrt (
  input  logic                      clk,
  input  logic                      advance,
  input  logic [rdra_pkg::S_W-1:0]  s,
  output logic [rdra_pkg::ROOT_W-1:0] root_q8
);
  import rdra_pkg::*;

  localparam int REM_W = ROOT_W + 1;

  // floor(sqrt(s * 2^16)), one root bit per stage
  logic [REM_W-1:0]  rem  [1:ROOT_W-1];
  logic [S_W-1:0]    sv   [1:ROOT_W-1];
  logic [ROOT_W-1:0] root [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int P = ROOT_W - 1 - k;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [S_W-1:0]    s_in;
    logic [N_W-1:0]    n_full;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign s_in = s;
    end else begin : g_next
      assign rem_in = rem[k];
      assign root_in = root[k];
      assign s_in = sv[k];
    end

    assign n_full = N_W'({s_in, 16'b0});
    assign cur = {rem_in, n_full[2*P+1 -: 2]};
    assign trial = (REM_W + 2)'({root_in, 2'b01});
    assign take = (cur >= trial);

    always_ff @(posedge clk) begin
      if (advance) begin
        root[k+1] <= {root_in[ROOT_W-2:0], take};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (advance) begin
          rem[k+1] <= take ? REM_W'(cur - trial) : REM_W'(cur);
          sv[k+1] <= s_in;
        end
      end
    end
  end

  assign root_q8 = root[ROOT_W];

endmodule

@@ hdl/rdra_cordic.sv @@
module rdra_cordic (
  input  logic                             clk,
  input  logic                             advance,
  input  logic [rdra_pkg::R_W-1:0]         r16,
  output logic signed [rdra_pkg::CZ_W-1:0] angle,
  output logic [rdra_pkg::R_W-1:0]         r16_out
);
  import rdra_pkg::*;

  // vectoring mode, x0 = 1.0, y0 = R, all Q.24
  logic signed [CX_W-1:0] x  [1:CORDIC_STEPS-1];
  logic signed [CX_W-1:0] y  [1:CORDIC_STEPS-1];
  logic signed [CZ_W-1:0] z  [1:CORDIC_STEPS];
  logic [R_W-1:0]         rc [1:CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [CZ_W-1:0] TAB = atan_entry(k);
    logic signed [CX_W-1:0] x_in;
    logic signed [CX_W-1:0] y_in;
    logic signed [CZ_W-1:0] z_in;
    logic [R_W-1:0]         r_in;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic                   up;

    if (k == 0) begin : g_first
      assign x_in = CX_W'(1) <<< 24;
      assign y_in = $signed(CX_W'({r16, 8'b0}));
      assign z_in = '0;
      assign r_in = r16;
    end else begin : g_next
      assign x_in = x[k];
      assign y_in = y[k];
      assign z_in = z[k];
      assign r_in = rc[k];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;
    assign up = !y_in[CX_W-1];

    always_ff @(posedge clk) begin
      if (advance) begin
        z[k+1] <= up ? z_in + TAB : z_in - TAB;
        rc[k+1] <= r_in;
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (advance) begin
          x[k+1] <= up ? x_in + ys : x_in - ys;
          y[k+1] <= up ? y_in - xs : y_in + xs;
        end
      end
    end
  end

  assign angle = z[CORDIC_STEPS];
  assign r16_out = rc[CORDIC_STEPS];

endmodule

@@ hdl/rdra_div.sv @@
module rdra_div (
  input  logic                             clk,
  input  logic                             advance,
  input  logic signed [rdra_pkg::CZ_W-1:0] angle,
  input  logic [rdra_pkg::R_W-1:0]         r16,
  output logic [rdra_pkg::Q_W-1:0]         theta
);
  import rdra_pkg::*;

  typedef struct packed {
    logic r_zero;
    logic z_pos;
    logic ovf;
  } div_flag_t;

  // theta = floor(angle * 2^16 / r16) clamped to [0, 1.0] (1.0 for r16 = 0), one quotient bit per stage
  logic [R_W-1:0]  rem0;
  logic [R_W-1:0]  d0;
  logic [Q_W-1:0]  nlow0;
  div_flag_t       fl0;

  logic [R_W-1:0]  rem   [1:Q_W-1];
  logic [R_W-1:0]  dv    [1:Q_W-1];
  logic [Q_W-1:0]  nlow  [1:Q_W-1];
  div_flag_t       fl    [1:Q_W];
  logic [Q_W-1:0]  q     [1:Q_W];

  logic [15:0] nhigh;
  assign nhigh = angle[24:9];

  always_ff @(posedge clk) begin
    if (advance) begin
      fl0.r_zero <= (r16 == '0);
      fl0.z_pos <= (angle > 0);
      fl0.ovf <= (R_W'(nhigh) >= r16);
      rem0 <= R_W'(nhigh);
      d0 <= r16;
      nlow0 <= {angle[8:0], 16'b0};
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int I = Q_W - 1 - j;
    logic [R_W-1:0] rem_in;
    logic [R_W-1:0] d_in;
    logic [Q_W-1:0] n_in;
    logic [Q_W-1:0] q_in;
    div_flag_t      fl_in;
    logic [R_W:0]   cur;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign d_in = d0;
      assign n_in = nlow0;
      assign q_in = '0;
      assign fl_in = fl0;
    end else begin : g_next
      assign rem_in = rem[j];
      assign d_in = dv[j];
      assign n_in = nlow[j];
      assign q_in = q[j];
      assign fl_in = fl[j];
    end

    assign cur = {rem_in, n_in[I]};
    assign ge = (cur >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (advance) begin
        q[j+1] <= {q_in[Q_W-2:0], ge};
        fl[j+1] <= fl_in;
      end
    end

    if (j < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (advance) begin
          rem[j+1] <= ge ? R_W'(cur - {1'b0, d_in}) : R_W'(cur);
          dv[j+1] <= d_in;
          nlow[j+1] <= n_in;
        end
      end
    end
  end

  always_comb begin
    if (fl[Q_W].r_zero) begin
      theta = THETA_ONE;
    end else if (!fl[Q_W].z_pos) begin
      theta = '0;
    end else if (fl[Q_W].ovf || q[Q_W] > THETA_ONE) begin
      theta = THETA_ONE;
    end else begin
      theta = q[Q_W];
    end
  end

endmodule

@@ hdl/rdra_poly.sv @@
module rdra_poly (
  input  logic                           clk,
  input  logic                           advance,
  input  logic [rdra_pkg::R_W-1:0]       r16,
  input  logic signed [rdra_pkg::D_W-1:0] dx,
  input  logic signed [rdra_pkg::D_W-1:0] dy,
  input  rdra_pkg::coeff_t               coeff,
  output rdra_pkg::axis_t                ax_row,
  output rdra_pkg::axis_t                ax_col
);
  import rdra_pkg::*;

  logic [2*R_W-1:0]         sq1;
  logic [2*R2_W-1:0]        sq2;
  logic [2*R2_W-1:0]        sq3;
  logic signed [K_W+R2_W:0] t1p;
  logic signed [K_W+R2_W:0] t2p;
  logic signed [K_W+R2_W:0] t3p;
  logic signed [SUM_W-1:0]  sum;
  logic signed [D_W+POLY_W-1:0] pr_row;
  logic signed [D_W+POLY_W-1:0] pr_col;
  logic [D_W+POLY_W-1:0]    mag_row;
  logic [D_W+POLY_W-1:0]    mag_col;

  logic [R2_W-1:0] r2_1, r2_2, r2_3, r4_2, r4_3, r6_3;
  logic signed [TERM_W-1:0] t1_4, t2_4, t3_4;
  logic signed [POLY_W-1:0] poly_5;
  logic signed [D_W-1:0] dx1, dy1, dx2, dy2, dx3, dy3, dx4, dy4, dx5, dy5;

  // powers of the radius, Q16.16
  assign sq1 = r16 * r16;
  assign sq2 = r2_1 * r2_1;
  assign sq3 = r4_2 * r2_2;

  always_ff @(posedge clk) begin
    if (advance) begin
      r2_1 <= sq1[2*R_W-1:16];
      dx1 <= dx;
      dy1 <= dy;

      r4_2 <= (|sq2[2*R2_W-1:R2_W+16]) ? '1 : sq2[R2_W+15:16];
      r2_2 <= r2_1;
      dx2 <= dx1;
      dy2 <= dy1;

      r6_3 <= (|sq3[2*R2_W-1:R2_W+16]) ? '1 : sq3[R2_W+15:16];
      r4_3 <= r4_2;
      r2_3 <= r2_2;
      dx3 <= dx2;
      dy3 <= dy2;
    end
  end

  // coefficient terms, floor shift by 24
  assign t1p = coeff.k1 * $signed({1'b0, r2_3});
  assign t2p = coeff.k2 * $signed({1'b0, r4_3});
  assign t3p = coeff.k3 * $signed({1'b0, r6_3});

  always_ff @(posedge clk) begin
    if (advance) begin
      t1_4 <= t1p[K_W+R2_W:24];
      t2_4 <= t2p[K_W+R2_W:24];
      t3_4 <= t3p[K_W+R2_W:24];
      dx4 <= dx3;
      dy4 <= dy3;
    end
  end

  // 1.0 + terms, saturated to the signed 32-bit range
  assign sum = SUM_W'(65536) + SUM_W'(t1_4) + SUM_W'(t2_4) + SUM_W'(t3_4);

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sum > SUM_W'(32'sh7fffffff)) begin
        poly_5 <= 32'sh7fffffff;
      end else if (sum < -(SUM_W'(33'sh080000000))) begin
        poly_5 <= 32'sh80000000;
      end else begin
        poly_5 <= sum[POLY_W-1:0];
      end
      dx5 <= dx4;
      dy5 <= dy4;
    end
  end

  // d * P, truncated toward zero
  assign pr_row = dx5 * poly_5;
  assign pr_col = dy5 * poly_5;
  assign mag_row = pr_row[D_W+POLY_W-1] ? -pr_row : pr_row;
  assign mag_col = pr_col[D_W+POLY_W-1] ? -pr_col : pr_col;

  always_ff @(posedge clk) begin
    if (advance) begin
      ax_row.neg <= pr_row[D_W+POLY_W-1];
      ax_row.nmag <= mag_row[NM_W+15:16];
      ax_col.neg <= pr_col[D_W+POLY_W-1];
      ax_col.nmag <= mag_col[NM_W+15:16];
    end
  end

endmodule

@@ hdl/radial_distortion_remap_address_core.sv @@
// radial lens distortion remap address generator
// a request carries one destination pixel (dest_row, dest_col); the result
// carries the source pixel to fetch, clamped into the image, and outside,
// set when either coordinate had to be clamped
// both channels are valid/stall: a request moves on a rising edge with
// valid high and stall low
// throughput: one request per clock, back to back, while the result is not held by result_stall
// pipeline: 76 register stages. the depth is set by the square root (one
// root bit per stage), 24 cordic steps for atan(R) and the 26-stage
// quotient unit for atan(R)/R
// the whole pipe advances together: while a result sits unaccepted under
// result_stall every stage holds and req_stall is raised, nothing is lost
// reset clears all valid bits and loads the register defaults
// (400 x 400 image, k1 = -0.01, f = 200, radius scale = 1/6)
// registers are written through cfg_write_enable/cfg_index/cfg_data; the user
// writes them only while no request is in flight, the block does not enforce it
module radial_distortion_remap_address_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [rdra_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rdra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  rdra_pkg::remap_req_t                req,
  output logic                                result_valid,
  input  logic                                result_stall,
  output rdra_pkg::remap_result_t             result
);
  import rdra_pkg::*;

  // stage positions
  localparam int ST_R16 = 2 + ROOT_W + 1;
  localparam int ST_THETA = ST_R16 + CORDIC_STEPS + DIV_STAGES;
  localparam int LAT = ST_THETA + 2;
  localparam int AX_DELAY = CORDIC_STEPS + DIV_STAGES - POLY_STAGES;

  // configuration registers
  logic [SIZE_W-1:0]  image_rows;
  logic [SIZE_W-1:0]  image_cols;
  coeff_t             coeff;
  logic [FOCAL_W-1:0] focal_length;
  logic [SCALE_W-1:0] radius_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
      image_cols <= COLS_RESET;
      coeff.k1 <= K1_RESET;
      coeff.k2 <= K2_RESET;
      coeff.k3 <= K3_RESET;
      focal_length <= FOCAL_RESET;
      radius_scale <= SCALE_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_IMAGE_ROWS: image_rows <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_COLS: image_cols <= cfg_data[SIZE_W-1:0];
        REG_COEFF_K1: coeff.k1 <= cfg_data[K_W-1:0];
        REG_COEFF_K2: coeff.k2 <= cfg_data[K_W-1:0];
        REG_COEFF_K3: coeff.k3 <= cfg_data[K_W-1:0];
        REG_FOCAL_LENGTH: focal_length <= cfg_data[FOCAL_W-1:0];
        REG_RADIUS_SCALE: radius_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the result is held
  logic advance;
  logic [LAT:1] vld;

  assign advance = !vld[LAT] || !result_stall;
  assign req_stall = !advance;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-1:1], req_valid};
    end
  end

  // stage 1: offsets from the image centre
  logic signed [D_W-1:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (advance) begin
      dx1 <= $signed(D_W'(req.dest_row)) - $signed(D_W'(image_rows[SIZE_W-1:1]));
      dy1 <= $signed(D_W'(req.dest_col)) - $signed(D_W'(image_cols[SIZE_W-1:1]));
    end
  end

  // stage 2: squared distance including the focal term
  logic [2*D_W-1:0]     dx_sq, dy_sq;
  logic [2*FOCAL_W-1:0] f_sq;
  logic [S_W-1:0]       s2;
  logic signed [D_W-1:0] dx2, dy2;

  // operands sign-extended to the full product width
  assign dx_sq = $unsigned((2 * D_W)'(dx1) * (2 * D_W)'(dx1));
  assign dy_sq = $unsigned((2 * D_W)'(dy1) * (2 * D_W)'(dy1));
  assign f_sq = focal_length * focal_length;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2 <= S_W'(dx_sq) + S_W'(dy_sq) + S_W'(f_sq);
      dx2 <= dx1;
      dy2 <= dy1;
    end
  end

  // square root; offsets ride alongside
  logic [ROOT_W-1:0] root_q8;
  logic signed [D_W-1:0] dxd [1:ROOT_W];
  logic signed [D_W-1:0] dyd [1:ROOT_W];

  rdra_isqrt u_isqrt (
    .clk     (clk),
    .advance (advance),
    .s       (s2),
    .root_q8 (root_q8)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      dxd[1] <= dx2;
      dyd[1] <= dy2;
      for (int i = 2; i <= ROOT_W; i++) begin
        dxd[i] <= dxd[i-1];
        dyd[i] <= dyd[i-1];
      end
    end
  end

  // radius in Q8.16, saturated to 24 bits
  logic [RMUL_W-1:0] rmul;
  logic [R_W-1:0]    r16;
  logic signed [D_W-1:0] dx_r, dy_r;

  assign rmul = root_q8 * radius_scale;

  always_ff @(posedge clk) begin
    if (advance) begin
      r16 <= (|rmul[RMUL_W-1:R_W+8]) ? '1 : rmul[R_W+7:8];
      dx_r <= dxd[ROOT_W];
      dy_r <= dyd[ROOT_W];
    end
  end

  // radial polynomial branch
  axis_t ax_row, ax_col;
  axis_t axr_d [1:AX_DELAY];
  axis_t axc_d [1:AX_DELAY];

  rdra_poly u_poly (
    .clk     (clk),
    .advance (advance),
    .r16     (r16),
    .dx      (dx_r),
    .dy      (dy_r),
    .coeff   (coeff),
    .ax_row  (ax_row),
    .ax_col  (ax_col)
  );

  // hold the scaled offsets until theta is ready
  always_ff @(posedge clk) begin
    if (advance) begin
      axr_d[1] <= ax_row;
      axc_d[1] <= ax_col;
      for (int i = 2; i <= AX_DELAY; i++) begin
        axr_d[i] <= axr_d[i-1];
        axc_d[i] <= axc_d[i-1];
      end
    end
  end

  // atan(R) then atan(R)/R
  logic signed [CZ_W-1:0] angle;
  logic [R_W-1:0]         r16_c;
  logic [Q_W-1:0]         theta;

  rdra_cordic u_cordic (
    .clk     (clk),
    .advance (advance),
    .r16     (r16),
    .angle   (angle),
    .r16_out (r16_c)
  );

  rdra_div u_div (
    .clk     (clk),
    .advance (advance),
    .angle   (angle),
    .r16     (r16_c),
    .theta   (theta)
  );

  // theta * n; theta never exceeds 1.0, which is a plain shift
  logic [PROD_W-1:0] prod_row, prod_col;
  logic              neg_row, neg_col;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_row <= theta[24] ? {axr_d[AX_DELAY].nmag, 24'b0}
                            : theta[23:0] * axr_d[AX_DELAY].nmag;
      prod_col <= theta[24] ? {axc_d[AX_DELAY].nmag, 24'b0}
                            : theta[23:0] * axc_d[AX_DELAY].nmag;
      neg_row <= axr_d[AX_DELAY].neg;
      neg_col <= axc_d[AX_DELAY].neg;
    end
  end

  // round half away from zero, add centre, clamp into image
  function automatic logic [COORD_BITS:0] map_axis(
    input logic [PROD_W-1:0] prod,
    input logic              neg,
    input logic [SIZE_W-1:0] size
  );
    logic [PROD_W:0]          rnd;
    logic [NM_W:0]            om;
    logic signed [NM_W+2:0]   ofs;
    logic signed [NM_W+2:0]   src;
    logic signed [NM_W+2:0]   lim;
    logic signed [NM_W+2:0]   cmax;
    rnd = {1'b0, prod} + (PROD_W + 1)'(1 << 23);
    om = rnd[PROD_W:24];
    ofs = $signed({2'b00, om});
    if (neg) begin
      ofs = -ofs;
    end
    src = $signed((NM_W + 3)'(size[SIZE_W-1:1])) + ofs;
    lim = (size == '0) ? '0 : $signed((NM_W + 3)'(size)) - (NM_W + 3)'(1);
    cmax = $signed((NM_W + 3)'({COORD_BITS{1'b1}}));
    if (lim > cmax) begin
      lim = cmax;
    end
    if (src < 0) begin
      map_axis = {1'b1, {COORD_BITS{1'b0}}};
    end else if (src > lim) begin
      map_axis = {1'b1, lim[COORD_BITS-1:0]};
    end else begin
      map_axis = {1'b0, src[COORD_BITS-1:0]};
    end
  endfunction

  logic [COORD_BITS:0] row_map, col_map;

  assign row_map = map_axis(prod_row, neg_row, image_rows);
  assign col_map = map_axis(prod_col, neg_col, image_cols);

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      result.source_row <= row_map[COORD_BITS-1:0];
      result.source_col <= col_map[COORD_BITS-1:0];
      result.outside <= row_map[COORD_BITS] | col_map[COORD_BITS];
    end
  end

endmodule
